@@ hw/rtl/tcce_pkg.sv @@
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants for the text console cursor editor.
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int COL_W  = 8;
    localparam int ROW_W  = 7;
    localparam int CHAR_W = 8;

    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    // register reset values
    localparam logic [8:0] COLS_RESET = 9'd256;
    localparam logic [7:0] ROWS_RESET = 8'd128;

    // register index, taken from paddr[2]
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    typedef enum logic [2:0] {
        FN_PUTC       = 3'd0,
        FN_LEFT       = 3'd1,
        FN_RIGHT      = 3'd2,
        FN_MARK       = 3'd3,
        FN_CLEAR_LINE = 3'd4,
        FN_RESET      = 3'd5,
        FN_READ       = 3'd6,
        FN_NOP        = 3'd7
    } func_t;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic              cell_written;
        logic [COL_W-1:0]  write_col;
        logic [ROW_W-1:0]  write_row;
        logic [CHAR_W-1:0] write_char;
        logic              line_cleared;
        logic [COL_W-1:0]  clear_start_col;
        logic [ROW_W-1:0]  clear_row_index;
        logic [CHAR_W-1:0] read_char;
    } res_t;

endpackage

@@ hw/rtl/text_console_cursor_editor.sv @@
// ----------------------------------------------------------------------------
// text_console_cursor_editor
// Character-cell store with a cursor and an editable region, one command at
// a time.
// ----------------------------------------------------------------------------
// Timing for the user: a command is taken only while cmd_stall is low, and
// the block then works on it alone. Putc, left, right, mark and the no-op
// command finish in their execute cycle; read cell of a cell inside the store
// passes through a read state as well, because the cell store has a
// registered read port. Clear edit line then blanks from the start column to
// the last column in use, or nothing when the start column lies past the
// last column in use, and the reset command blanks every cell of the store.
// Both walk the store through its single write port, one cell per cycle,
// using the same incrementer that moves the cursor. After rst_n is released
// the same clearing pass runs first, with cmd_stall high until it is done;
// configuration writes are taken throughout. A finished result sits in an
// output register, so the next command may be taken while the previous
// result still waits on rsp_stall.
// ----------------------------------------------------------------------------
module text_console_cursor_editor
    import tcce_pkg::*;
#(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 128
) (
    input  logic               clk,
    input  logic               rst_n,

    // command channel
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  logic [2:0]         func,
    input  logic [CHAR_W-1:0]  char_in,
    input  logic [COL_W-1:0]   read_col,
    input  logic [ROW_W-1:0]   read_row,

    // result channel
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [COL_W-1:0]   cursor_col,
    output logic [ROW_W-1:0]   cursor_row,
    output logic               cell_written,
    output logic [COL_W-1:0]   write_col,
    output logic [ROW_W-1:0]   write_row,
    output logic [CHAR_W-1:0]  write_char,
    output logic               line_cleared,
    output logic [COL_W-1:0]   clear_start_col,
    output logic [ROW_W-1:0]   clear_row_index,
    output logic [CHAR_W-1:0]  read_char,

    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Store address is {row, col} with the column field rounded up to a
    // power of two, so no multiply is needed.
    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int AW    = CW + RW;
    localparam int DEPTH = MAX_ROWS << CW;
    localparam int ALU_W = (AW > COL_W) ? AW : COL_W;

    localparam logic [AW-1:0]    LAST_ADDR  = AW'(DEPTH - 1);
    localparam logic [8:0]       MAX_COLS_W = 9'(MAX_COLS);
    localparam logic [7:0]       MAX_ROWS_W = 8'(MAX_ROWS);
    localparam logic [COL_W-1:0] COL_TOP    = COL_W'(MAX_COLS - 1);
    localparam logic [ROW_W-1:0] ROW_TOP    = ROW_W'(MAX_ROWS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CLR_LINE,
        S_CLR_ALL,
        S_READ,
        S_DONE
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [8:0] cols_raw_reg;
    logic [7:0] rows_raw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_raw_reg <= COLS_RESET;
            rows_raw_reg <= ROWS_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_COLS: cols_raw_reg <= pwdata[8:0];
                REG_ROWS: rows_raw_reg <= pwdata[7:0];
                default:  ;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ROWS) ? {24'b0, rows_raw_reg} : {23'b0, cols_raw_reg};

    // Last usable column and row, with zero acting as one and large values
    // clamped to the store size.
    logic [COL_W-1:0] cols_last;
    logic [ROW_W-1:0] rows_last;

    always_comb
    begin
        if (cols_raw_reg == 9'd0)
            cols_last = '0;
        else if (cols_raw_reg > MAX_COLS_W)
            cols_last = COL_TOP;
        else
            cols_last = COL_W'(cols_raw_reg - 9'd1);

        if (rows_raw_reg == 8'd0)
            rows_last = '0;
        else if (rows_raw_reg > MAX_ROWS_W)
            rows_last = ROW_TOP;
        else
            rows_last = ROW_W'(rows_raw_reg - 8'd1);
    end

    // ------------------------------------------------------------------
    // Control and editor state
    // ------------------------------------------------------------------
    state_t            state_reg;
    logic              pend_reg;      // reset command waits for its result
    logic [AW-1:0]     sweep_reg;
    logic [COL_W-1:0]  cur_col_reg,   start_col_reg, end_col_reg;
    logic [ROW_W-1:0]  cur_row_reg,   start_row_reg, end_row_reg;
    logic              rsp_valid_reg;
    res_t              rsp_reg;
    res_t              stage_reg;

    // latched command
    logic [2:0]        func_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [COL_W-1:0]  rcol_reg;
    logic [ROW_W-1:0]  rrow_reg;

    logic [CHAR_W-1:0] mem_q_reg;

    func_t cmd_func;
    assign cmd_func = func_t'(func_reg);

    // ------------------------------------------------------------------
    // Shared incrementer: cursor steps in the execute cycle, the sweep
    // address in the clearing states.
    // ------------------------------------------------------------------
    logic             sel_row, dec;
    logic [ALU_W-1:0] alu_a, alu_b, alu_sum;
    logic [COL_W-1:0] col_inc;
    logic [ROW_W-1:0] row_inc;
    logic [AW-1:0]    sweep_inc;

    logic at_start, col_lt_last, row_lt_last, past_end;

    assign at_start    = (cur_row_reg == start_row_reg) && (cur_col_reg <= start_col_reg);
    assign col_lt_last = cur_col_reg < cols_last;
    assign row_lt_last = cur_row_reg < rows_last;
    assign past_end    = (cur_row_reg > end_row_reg) ||
                         ((cur_row_reg == end_row_reg) && (cur_col_reg >= end_col_reg));

    always_comb
    begin
        sel_row = 1'b0;
        dec     = 1'b0;
        case (cmd_func)
            FN_PUTC:
            begin
                if (char_reg == CHAR_BS)
                begin
                    sel_row = (cur_col_reg == '0);
                    dec     = 1'b1;
                end
                else if (char_reg == CHAR_NL)
                    sel_row = 1'b1;
                else
                    sel_row = !col_lt_last;
            end
            FN_LEFT:
            begin
                sel_row = (cur_col_reg == '0);
                dec     = 1'b1;
            end
            FN_RIGHT: sel_row = !col_lt_last;
            default:  ;
        endcase
    end

    // sweeps always count up, whatever command was latched last
    always_comb
    begin
        if (state_reg == S_EXEC)
        begin
            alu_a = sel_row ? ALU_W'(cur_row_reg) : ALU_W'(cur_col_reg);
            alu_b = dec ? '1 : ALU_W'(1);
        end
        else
        begin
            alu_a = ALU_W'(sweep_reg);
            alu_b = ALU_W'(1);
        end
    end

    assign alu_sum   = alu_a + alu_b;
    assign col_inc   = alu_sum[COL_W-1:0];
    assign row_inc   = alu_sum[ROW_W-1:0];
    assign sweep_inc = alu_sum[AW-1:0];

    // ------------------------------------------------------------------
    // Execute cycle: next cursor and region, cell write, result fields
    // ------------------------------------------------------------------
    logic [COL_W-1:0]  nc, nsc, nec;
    logic [ROW_W-1:0]  nr, nsr, ner;
    logic              exec_we;
    logic [AW-1:0]     exec_waddr;
    logic [CHAR_W-1:0] exec_wdata;
    logic              go_line, go_all, go_read;
    logic              rd_in_range;
    res_t              exec_res;

    assign rd_in_range = ({1'b0, rcol_reg} < MAX_COLS_W) && ({1'b0, rrow_reg} < MAX_ROWS_W);

    always_comb
    begin
        nc         = cur_col_reg;
        nr         = cur_row_reg;
        nsc        = start_col_reg;
        nsr        = start_row_reg;
        nec        = end_col_reg;
        ner        = end_row_reg;
        exec_we    = 1'b0;
        exec_waddr = {cur_row_reg[RW-1:0], cur_col_reg[CW-1:0]};
        exec_wdata = char_reg;
        go_line    = 1'b0;
        go_all     = 1'b0;
        go_read    = 1'b0;
        exec_res   = '0;

        case (cmd_func)
            FN_PUTC:
            begin
                if (char_reg == CHAR_BS)
                begin
                    if (!at_start)
                    begin
                        if (cur_col_reg != '0)
                            nc = col_inc;
                        else if (cur_row_reg > start_row_reg)
                        begin
                            nr = row_inc;
                            nc = cols_last;
                        end
                        // col 0 above the start row: stays, space still written
                        exec_we               = 1'b1;
                        exec_waddr            = {nr[RW-1:0], nc[CW-1:0]};
                        exec_wdata            = CHAR_SPACE;
                        exec_res.cell_written = 1'b1;
                        exec_res.write_col    = nc;
                        exec_res.write_row    = nr;
                        exec_res.write_char   = CHAR_SPACE;
                        if ((end_row_reg > nr) || ((end_row_reg == nr) && (end_col_reg > nc)))
                        begin
                            nec = nc;
                            ner = nr;
                        end
                    end
                end
                else if (char_reg == CHAR_NL)
                begin
                    nc = '0;
                    if (row_lt_last)
                        nr = row_inc;
                    if (nr > end_row_reg)
                    begin
                        ner = nr;
                        nec = '0;
                    end
                end
                else
                begin
                    exec_we               = 1'b1;
                    exec_res.cell_written = 1'b1;
                    exec_res.write_col    = cur_col_reg;
                    exec_res.write_row    = cur_row_reg;
                    exec_res.write_char   = char_reg;
                    if (col_lt_last)
                        nc = col_inc;
                    else
                    begin
                        nc = '0;
                        if (row_lt_last)
                            nr = row_inc;
                    end
                    if ((nr > end_row_reg) || ((nr == end_row_reg) && (nc > end_col_reg)))
                    begin
                        nec = nc;
                        ner = nr;
                    end
                end
            end
            FN_LEFT:
            begin
                if (!at_start)
                begin
                    if (cur_col_reg != '0)
                        nc = col_inc;
                    else if (cur_row_reg > start_row_reg)
                    begin
                        nr = row_inc;
                        nc = cols_last;
                    end
                end
            end
            FN_RIGHT:
            begin
                if (!past_end)
                begin
                    if (col_lt_last)
                        nc = col_inc;
                    else if (row_lt_last)
                    begin
                        nc = '0;
                        nr = row_inc;
                    end
                end
            end
            FN_MARK:
            begin
                nsc = cur_col_reg;
                nsr = cur_row_reg;
                nec = cur_col_reg;
                ner = cur_row_reg;
            end
            FN_CLEAR_LINE:
            begin
                nc                       = start_col_reg;
                nr                       = start_row_reg;
                nec                      = start_col_reg;
                ner                      = start_row_reg;
                exec_res.line_cleared    = 1'b1;
                exec_res.clear_start_col = start_col_reg;
                exec_res.clear_row_index = start_row_reg;
                // start at or past the columns in use: nothing to blank
                go_line                  = (start_col_reg <= cols_last);
            end
            FN_RESET:
            begin
                nc     = '0;
                nr     = '0;
                nsc    = '0;
                nsr    = '0;
                nec    = '0;
                ner    = '0;
                go_all = 1'b1;
            end
            FN_READ:
            begin
                // outside the store reads as a space without a lookup
                if (rd_in_range)
                    go_read = 1'b1;
                else
                    exec_res.read_char = CHAR_SPACE;
            end
            default: ;
        endcase

        exec_res.cursor_col = nc;
        exec_res.cursor_row = nr;
    end

    // ------------------------------------------------------------------
    // Cell store: one write port, one registered read port
    // ------------------------------------------------------------------
    logic [CHAR_W-1:0] mem [DEPTH];
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CHAR_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = sweep_reg;
        mem_wdata = CHAR_SPACE;
        case (state_reg)
            S_EXEC:
            begin
                mem_we    = exec_we;
                mem_waddr = exec_waddr;
                mem_wdata = exec_wdata;
            end
            S_CLR_LINE, S_CLR_ALL: mem_we = 1'b1;
            default: ;
        endcase
    end

    assign mem_raddr = {rrow_reg[RW-1:0], rcol_reg[CW-1:0]};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_q_reg <= mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    // Completion: which state delivers a result, and with what fields
    // ------------------------------------------------------------------
    logic line_done, all_done, out_free, fin;
    res_t fin_res;

    assign line_done = (sweep_reg[CW-1:0] == cols_last[CW-1:0]);
    assign all_done  = (sweep_reg == LAST_ADDR);
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        fin     = 1'b0;
        fin_res = stage_reg;
        case (state_reg)
            S_EXEC:
            begin
                fin     = !(go_line || go_all || go_read);
                fin_res = exec_res;
            end
            S_CLR_LINE: fin = line_done;
            S_CLR_ALL:  fin = all_done && pend_reg;
            S_READ:
            begin
                fin               = 1'b1;
                fin_res.read_char = (mem_q_reg == '0) ? CHAR_SPACE : mem_q_reg;
            end
            S_DONE:     fin = 1'b1;
            default:    ;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR_ALL;   // clearing pass after reset
            pend_reg      <= 1'b0;
            sweep_reg     <= '0;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            start_col_reg <= '0;
            start_row_reg <= '0;
            end_col_reg   <= '0;
            end_row_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (fin && out_free)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        func_reg  <= func;
                        char_reg  <= char_in;
                        rcol_reg  <= read_col;
                        rrow_reg  <= read_row;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    cur_col_reg   <= nc;
                    cur_row_reg   <= nr;
                    start_col_reg <= nsc;
                    start_row_reg <= nsr;
                    end_col_reg   <= nec;
                    end_row_reg   <= ner;
                    // commands that go on past the execute state keep their fields here until done
                    if (!fin)
                        stage_reg <= exec_res;
                    if (go_line)
                    begin
                        sweep_reg <= {start_row_reg[RW-1:0], start_col_reg[CW-1:0]};
                        state_reg <= S_CLR_LINE;
                    end
                    else if (go_all)
                    begin
                        sweep_reg <= '0;
                        pend_reg  <= 1'b1;
                        state_reg <= S_CLR_ALL;
                    end
                    else if (go_read)
                        state_reg <= S_READ;
                end
                S_CLR_LINE:
                begin
                    if (!line_done)
                        sweep_reg <= sweep_inc;
                end
                S_CLR_ALL:
                begin
                    if (!all_done)
                        sweep_reg <= sweep_inc;
                    else if (!pend_reg)
                        state_reg <= S_IDLE;
                end
                default: ;
            endcase

            // result goes straight out when the output register is free,
            // else it parks in the stage register
            if (fin)
            begin
                pend_reg <= 1'b0;
                if (out_free)
                begin
                    rsp_reg   <= fin_res;
                    state_reg <= S_IDLE;
                end
                else
                begin
                    stage_reg <= fin_res;
                    state_reg <= S_DONE;
                end
            end
        end
    end

    assign cmd_stall       = (state_reg != S_IDLE);
    assign rsp_valid       = rsp_valid_reg;
    assign cursor_col      = rsp_reg.cursor_col;
    assign cursor_row      = rsp_reg.cursor_row;
    assign cell_written    = rsp_reg.cell_written;
    assign write_col       = rsp_reg.write_col;
    assign write_row       = rsp_reg.write_row;
    assign write_char      = rsp_reg.write_char;
    assign line_cleared    = rsp_reg.line_cleared;
    assign clear_start_col = rsp_reg.clear_start_col;
    assign clear_row_index = rsp_reg.clear_row_index;
    assign read_char       = rsp_reg.read_char;

endmodule

@@ hw/rtl/tcce_checker.sv @@
// ----------------------------------------------------------------------------
// tcce_checker
// Port-level checks for the text console cursor editor, bound to the top.
// ----------------------------------------------------------------------------
module tcce_checker
    import tcce_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_stall,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input logic [COL_W-1:0]  cursor_col,
    input logic [ROW_W-1:0]  cursor_row,
    input logic              cell_written,
    input logic [COL_W-1:0]  write_col,
    input logic [ROW_W-1:0]  write_row,
    input logic [CHAR_W-1:0] write_char,
    input logic              line_cleared,
    input logic [COL_W-1:0]  clear_start_col,
    input logic [ROW_W-1:0]  clear_row_index,
    input logic [CHAR_W-1:0] read_char
);

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(cursor_col) && $stable(cursor_row)
            && $stable(cell_written) && $stable(write_char) && $stable(read_char))
        else $error("stalled result changed");

    // a taken command keeps the block busy for at least its execute cycle
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("command taken while previous one executes");

    // write fields are zero when no cell was written
    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !cell_written |-> write_col == '0 && write_row == '0 && write_char == '0)
        else $error("write fields set without a cell write");

    // clearing the edit line parks the cursor at the region start
    a_clear_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && line_cleared |->
            cursor_col == clear_start_col && cursor_row == clear_row_index && !cell_written)
        else $error("cursor not at region start after line clear");

endmodule

bind text_console_cursor_editor tcce_checker u_tcce_checker (.*);

@@ test/text_console_cursor_editor_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_editor_tb
// Self-checking bench for the console editor: commands go in on the valid /
// stall command channel, every result is checked against a local model of
// the cell store, cursor and edit region, and the geometry registers are
// reprogrammed over the APB port between bursts of traffic.
// ----------------------------------------------------------------------------
module text_console_cursor_editor_tb;
    import tcce_pkg::*;

    localparam int NUM_COLS     = 256;
    localparam int NUM_ROWS     = 128;
    localparam int CELL_COUNT   = 1 << (COL_W + ROW_W);
    localparam int PHASES       = 12;    // random phases, last one runs flat out
    localparam int PHASE_ITEMS  = 96;    // about 1150 random commands in total
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_LIMIT = 10;

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic              clk;
    logic              rst_n;
    logic              cmd_valid;
    logic              cmd_stall;
    logic [2:0]        func;
    logic [CHAR_W-1:0] char_in;
    logic [COL_W-1:0]  read_col;
    logic [ROW_W-1:0]  read_row;
    logic              rsp_valid;
    logic              rsp_stall;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic              cell_written;
    logic [COL_W-1:0]  write_col;
    logic [ROW_W-1:0]  write_row;
    logic [CHAR_W-1:0] write_char;
    logic              line_cleared;
    logic [COL_W-1:0]  clear_start_col;
    logic [ROW_W-1:0]  clear_row_index;
    logic [CHAR_W-1:0] read_char;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    text_console_cursor_editor #(
        .MAX_COLS(NUM_COLS),
        .MAX_ROWS(NUM_ROWS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .func(func),
        .char_in(char_in),
        .read_col(read_col),
        .read_row(read_row),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .cursor_col(cursor_col),
        .cursor_row(cursor_row),
        .cell_written(cell_written),
        .write_col(write_col),
        .write_row(write_row),
        .write_char(write_char),
        .line_cleared(line_cleared),
        .clear_start_col(clear_start_col),
        .clear_row_index(clear_row_index),
        .read_char(read_char),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // ------------------------------------------------------------------------
    // Model state: screen contents, cursor, edit region (anchor = start,
    // limit = end) and the raw register values as written.
    // ------------------------------------------------------------------------
    logic [CHAR_W-1:0] screen [0:CELL_COUNT-1];   // indexed by {row, col}
    logic [COL_W-1:0]  caret_x, anchor_x, limit_x;
    logic [ROW_W-1:0]  caret_y, anchor_y, limit_y;
    logic [8:0]        width_reg;
    logic [7:0]        height_reg;

    res_t pending_reports [$];    // results still owed by the DUT, oldest first
    int   mismatches;
    bit   quiet_tail;             // no idling on either side in the final phase
    int   resets_left;            // reset command walks the whole store: keep rare

    // register value 0 behaves as 1, anything above the store size saturates
    function automatic int active_cols();
        if (width_reg == 0)
            return 1;
        return (width_reg > NUM_COLS) ? NUM_COLS : int'(width_reg);
    endfunction

    function automatic int active_rows();
        if (height_reg == 0)
            return 1;
        return (height_reg > NUM_ROWS) ? NUM_ROWS : int'(height_reg);
    endfunction

    function automatic void clear_console();
        caret_x  = '0;
        caret_y  = '0;
        anchor_x = '0;
        anchor_y = '0;
        limit_x  = '0;
        limit_y  = '0;
        foreach (screen[i])
            screen[i] = CHAR_SPACE;
    endfunction

    // Step the cursor back one cell; returns 1 when pinned at the edit start.
    // Column 0 only climbs to the row above while still below the start row.
    function automatic bit retreat_cursor();
        if (caret_y == anchor_y && caret_x <= anchor_x)
            return 1'b1;
        if (caret_x > 0)
            caret_x = caret_x - 1'b1;
        else if (caret_y > anchor_y)
        begin
            caret_y = caret_y - 1'b1;
            caret_x = COL_W'(active_cols() - 1);
        end
        return 1'b0;
    endfunction

    // Apply one command to the model and return the report it must produce.
    function automatic res_t apply_console_cmd(func_t fn, logic [CHAR_W-1:0] ch,
                                               logic [COL_W-1:0] rcol,
                                               logic [ROW_W-1:0] rrow);
        res_t rep;
        int   ncols;
        int   nrows;
        int   x;
        rep   = '0;
        ncols = active_cols();
        nrows = active_rows();
        case (fn)
            FN_PUTC:
            begin
                if (ch == CHAR_BS)
                begin
                    if (!retreat_cursor())
                    begin
                        screen[{caret_y, caret_x}] = CHAR_SPACE;
                        rep.cell_written = 1'b1;
                        rep.write_col    = caret_x;
                        rep.write_row    = caret_y;
                        rep.write_char   = CHAR_SPACE;
                        // region end pulled back to the cursor
                        if (limit_y > caret_y || (limit_y == caret_y && limit_x > caret_x))
                        begin
                            limit_x = caret_x;
                            limit_y = caret_y;
                        end
                    end
                end
                else if (ch == CHAR_NL)
                begin
                    caret_x = '0;
                    if (caret_y < nrows - 1)
                        caret_y = caret_y + 1'b1;
                    if (caret_y > limit_y)
                    begin
                        limit_y = caret_y;
                        limit_x = caret_x;
                    end
                end
                else
                begin
                    screen[{caret_y, caret_x}] = ch;
                    rep.cell_written = 1'b1;
                    rep.write_col    = caret_x;
                    rep.write_row    = caret_y;
                    rep.write_char   = ch;
                    // wrap at the last column, stick on the last row
                    if (caret_x < ncols - 1)
                        caret_x = caret_x + 1'b1;
                    else
                    begin
                        caret_x = '0;
                        if (caret_y < nrows - 1)
                            caret_y = caret_y + 1'b1;
                    end
                    if (caret_y > limit_y || (caret_y == limit_y && caret_x > limit_x))
                    begin
                        limit_x = caret_x;
                        limit_y = caret_y;
                    end
                end
            end
            FN_LEFT:
                void'(retreat_cursor());
            FN_RIGHT:
            begin
                if (!(caret_y > limit_y || (caret_y == limit_y && caret_x >= limit_x)))
                begin
                    if (caret_x < ncols - 1)
                        caret_x = caret_x + 1'b1;
                    else if (caret_y < nrows - 1)
                    begin
                        caret_x = '0;
                        caret_y = caret_y + 1'b1;
                    end
                end
            end
            FN_MARK:
            begin
                anchor_x = caret_x;
                anchor_y = caret_y;
                limit_x  = caret_x;
                limit_y  = caret_y;
            end
            FN_CLEAR_LINE:
            begin
                caret_x = anchor_x;
                caret_y = anchor_y;
                // a start column at or past the column count blanks nothing
                for (x = int'(anchor_x); x < ncols; x++)
                    screen[{anchor_y, COL_W'(x)}] = CHAR_SPACE;
                limit_x = anchor_x;
                limit_y = anchor_y;
                rep.line_cleared    = 1'b1;
                rep.clear_start_col = anchor_x;
                rep.clear_row_index = anchor_y;
            end
            FN_RESET:
                clear_console();
            FN_READ:
                rep.read_char = (screen[{rrow, rcol}] == '0) ? CHAR_SPACE
                                                            : screen[{rrow, rcol}];
            default:
                ;
        endcase
        rep.cursor_col = caret_x;
        rep.cursor_row = caret_y;
        return rep;
    endfunction

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog for a hung run; the worst case is five full-store clears plus the
    // line clears, all with maximum stalls.
    initial
    begin
        #30_000_000;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random stall bursts with free stretches in between, nothing
    // once the tail phase starts. One update per negedge.
    // ------------------------------------------------------------------------
    initial
    begin
        int hold;
        bit stall_now;
        hold      = 0;
        stall_now = 1'b0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold == 0)
            begin
                stall_now = ($urandom_range(0, 2) == 0);
                hold      = stall_now ? $urandom_range(1, 9) : $urandom_range(1, 30);
            end
            hold--;
            rsp_stall <= stall_now && !quiet_tail;
        end
    end

    function automatic void note_mismatch(string field, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, field, want, got);
    endfunction

    // Checker: each result transfer is compared against the oldest report owed.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] result transfer with no command outstanding", $time);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (cursor_col !== want.cursor_col)
                    note_mismatch("cursor_col", 32'(want.cursor_col), 32'(cursor_col));
                if (cursor_row !== want.cursor_row)
                    note_mismatch("cursor_row", 32'(want.cursor_row), 32'(cursor_row));
                if (cell_written !== want.cell_written)
                    note_mismatch("cell_written", 32'(want.cell_written),
                                  32'(cell_written));
                if (write_col !== want.write_col)
                    note_mismatch("write_col", 32'(want.write_col), 32'(write_col));
                if (write_row !== want.write_row)
                    note_mismatch("write_row", 32'(want.write_row), 32'(write_row));
                if (write_char !== want.write_char)
                    note_mismatch("write_char", 32'(want.write_char), 32'(write_char));
                if (line_cleared !== want.line_cleared)
                    note_mismatch("line_cleared", 32'(want.line_cleared),
                                  32'(line_cleared));
                if (clear_start_col !== want.clear_start_col)
                    note_mismatch("clear_start_col", 32'(want.clear_start_col),
                                  32'(clear_start_col));
                if (clear_row_index !== want.clear_row_index)
                    note_mismatch("clear_row_index", 32'(want.clear_row_index),
                                  32'(clear_row_index));
                if (read_char !== want.read_char)
                    note_mismatch("read_char", 32'(want.read_char), 32'(read_char));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------

    // Present one command, optionally after an idle gap, and hold it until the
    // transfer; the model is stepped at the accepting edge.
    task automatic send_cmd(input func_t fn, input logic [CHAR_W-1:0] ch,
                            input logic [COL_W-1:0] rcol, input logic [ROW_W-1:0] rrow);
        int gap;
        gap = (quiet_tail || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(1, 9);
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        func      <= fn;
        char_in   <= ch;
        read_col  <= rcol;
        read_row  <= rrow;
        do
            @(posedge clk);
        while (cmd_stall);
        pending_reports.push_back(apply_console_cmd(fn, ch, rcol, rrow));
    endtask

    // command with don't-care read coordinates
    task automatic edit_cmd(input func_t fn, input logic [CHAR_W-1:0] ch);
        send_cmd(fn, ch, COL_W'($urandom), ROW_W'($urandom));
    endtask

    task automatic read_cell(input logic [COL_W-1:0] rcol, input logic [ROW_W-1:0] rrow);
        send_cmd(FN_READ, CHAR_W'($urandom), rcol, rrow);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Geometry changes only while the block is idle: every command answered.
    task automatic set_geometry(input logic [8:0] cols_val, input logic [7:0] rows_val);
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        apb_write({REG_COLS, 2'b00}, {23'b0, cols_val});
        width_reg = cols_val;
        apb_write({REG_ROWS, 2'b00}, {24'b0, rows_val});
        height_reg = rows_val;
    endtask

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // 3x2 screen: wrap at the last column, stick on the last row, NUL stored
    // and read back as a space.
    task automatic test_typing_wrap();
        set_geometry(9'd3, 8'd2);
        edit_cmd(FN_PUTC, 8'h41);
        edit_cmd(FN_PUTC, 8'h00);
        edit_cmd(FN_PUTC, 8'hFF);     // last column, wraps to row 1
        edit_cmd(FN_PUTC, 8'h42);
        edit_cmd(FN_PUTC, 8'h43);
        edit_cmd(FN_PUTC, 8'h44);     // last cell, row does not advance
        edit_cmd(FN_PUTC, CHAR_NL);   // newline on the last row
        read_cell(8'd0, 7'd0);
        read_cell(8'd1, 7'd0);
    endtask

    // Left / right / backspace against the region bounds, then mark and clear.
    task automatic test_cursor_region();
        edit_cmd(FN_LEFT, 8'h00);       // column 0 climbs to the row above
        edit_cmd(FN_PUTC, CHAR_BS);     // erase, region end pulled back
        edit_cmd(FN_RIGHT, 8'h00);      // at region end: no move
        edit_cmd(FN_LEFT, 8'h00);
        edit_cmd(FN_LEFT, 8'h00);       // pinned at region start
        edit_cmd(FN_PUTC, CHAR_BS);     // pinned, nothing written
        edit_cmd(FN_RIGHT, 8'h00);
        edit_cmd(FN_MARK, 8'h00);
        edit_cmd(FN_CLEAR_LINE, 8'h00);
    endtask

    // Register extremes: start column at the column count, cursor beyond
    // the columns in use, zero acting as one, oversize values saturating.
    task automatic test_register_extremes();
        set_geometry(9'd1, 8'd1);
        edit_cmd(FN_CLEAR_LINE, 8'h00); // start col 1 >= 1 column: nothing blanked
        edit_cmd(FN_PUTC, 8'h51);       // cursor outside the columns, wraps
        read_cell(8'd1, 7'd0);
        set_geometry(9'd0, 8'd0);
        edit_cmd(FN_PUTC, 8'h52);
        set_geometry(9'd511, 8'd255);
        edit_cmd(FN_PUTC, CHAR_NL);
    endtask

    task automatic test_reset_and_nop();
        edit_cmd(FN_NOP, 8'hA5);
        edit_cmd(FN_RESET, 8'h00);
        read_cell(8'd1, 7'd0);
        read_cell(8'd255, 7'd127);
    endtask

    // ------------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------------
    function automatic logic [8:0] pick_cols();
        case ($urandom_range(0, 7))
            0, 1, 2: return 9'($urandom_range(2, 6));
            3:       return 9'($urandom_range(7, 40));
            4:       return 9'($urandom_range(1, 256));
            5:       return 9'd256;
            6:       return 9'($urandom_range(257, 511));
            default: return 9'd0;
        endcase
    endfunction

    function automatic logic [7:0] pick_rows();
        case ($urandom_range(0, 7))
            0, 1, 2: return 8'($urandom_range(2, 4));
            3:       return 8'($urandom_range(5, 20));
            4:       return 8'($urandom_range(1, 128));
            5:       return 8'd128;
            6:       return 8'($urandom_range(129, 255));
            default: return 8'd0;
        endcase
    endfunction

    // Mostly editing traffic: typing, erasing and cursor moves inside a region,
    // reads near the cursor and anywhere, with the odd clear, reset and no-op mixed in.
    task automatic random_edit_cmd();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            edit_cmd(FN_PUTC, CHAR_W'($urandom));
        else if (pick < 55)
            edit_cmd(FN_PUTC, CHAR_BS);
        else if (pick < 60)
            edit_cmd(FN_PUTC, CHAR_NL);
        else if (pick < 67)
            edit_cmd(FN_LEFT, CHAR_W'($urandom));
        else if (pick < 74)
            edit_cmd(FN_RIGHT, CHAR_W'($urandom));
        else if (pick < 78)
            edit_cmd(FN_MARK, CHAR_W'($urandom));
        else if (pick < 81)
            edit_cmd(FN_CLEAR_LINE, CHAR_W'($urandom));
        else if (pick < 89)
            read_cell(caret_x - COL_W'($urandom_range(0, 2)),
                      caret_y - ROW_W'($urandom_range(0, 1)));
        else if (pick < 96)
            read_cell(COL_W'($urandom), ROW_W'($urandom));
        else if (pick < 99 || resets_left == 0)
            edit_cmd(FN_NOP, CHAR_W'($urandom));
        else
        begin
            resets_left--;
            edit_cmd(FN_RESET, CHAR_W'($urandom));
        end
    endtask

    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < PHASES; phase++)
        begin
            // first two phases pin the largest and smallest screens
            if (phase == 0)
                set_geometry(9'd256, 8'd128);
            else if (phase == 1)
                set_geometry(9'd1, 8'd1);
            else
                set_geometry(pick_cols(), pick_rows());
            quiet_tail = (phase == PHASES - 1);
            edit_cmd(FN_MARK, CHAR_W'($urandom));
            repeat (PHASE_ITEMS - 1)
                random_edit_cmd();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        cmd_valid   = 1'b0;
        func        = FN_NOP;
        char_in     = '0;
        read_col    = '0;
        read_row    = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        mismatches  = 0;
        quiet_tail  = 1'b0;
        resets_left = 3;
        width_reg   = COLS_RESET;
        height_reg  = ROWS_RESET;
        clear_console();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // the power-up clearing pass holds cmd_stall; send_cmd just waits it out
        test_typing_wrap();
        test_cursor_region();
        test_register_extremes();
        test_reset_and_nop();
        test_random_traffic();

        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        // catch any stray extra result
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
